// ----- src/cfa_pkg.sv -----
// Package for the contiguous fit allocator: constants, codes and state type.
`timescale 1ns / 1ps
package cfa_pkg;
   localparam int MaxSegments = 16;
   localparam int AddrBits    = 21;
   localparam int OwnerBits   = 8;
   localparam logic [20:0] MemorySizeReset = 21'h100000;

   typedef enum logic [1:0] {
      OP_REQUEST = 2'd0,
      OP_RELEASE = 2'd1,
      OP_COMPACT = 2'd2,
      OP_REPORT  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2,
      FIT_OTHER = 2'd3
   } fit_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_HOLE = 2'd1,
      ST_FULL    = 2'd2,
      ST_ABSENT  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN,
      S_SHIFT_UP,
      S_INSERT,
      S_SHIFT_DOWN,
      S_COMPACT,
      S_REPORT,
      S_OUT
   } state_type;
endpackage

// ----- src/contiguous_fit_allocator.sv -----
// Top level of the contiguous fit allocator with its segment table and sequencer.
`timescale 1ns / 1ps
// Usage: one input item per transfer on req_ (tdata: operation, strategy,
// process_id, request_size from the low bit up). Results leave on rsp_
// (tdata: status, region_start, region_end, region_owner, region_used;
// tlast marks the final result of an item). csr_ writes memory_size.
// The block takes one item at a time; req_tready is high only in the idle
// state between items. One shared compare and subtract unit visits the
// table entries in turn. A request scans, then moves each later entry up
// one slot; a release scans, then moves each later entry down one slot; a
// compact packs the entries from address zero; a report walks the entries,
// plus a trailing unused region.
// A result is held on rsp_ until taken; a stalled receiver stalls the
// walk. Reset empties the table (count to zero) and sets memory_size to
// 21'h100000; no clearing pass is needed.
module contiguous_fit_allocator #(
   parameter int MAX_SEGMENTS = cfa_pkg::MaxSegments
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // operation[1:0], strategy[3:2], process_id[11:4], request_size[32:12]
   input  logic [39:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // status[1:0], region_start[22:2], region_end[43:23], region_owner[51:44],
   // region_used[52]
   output logic [55:0] rsp_tdata,
   output logic rsp_tlast,
   input  logic csr_we,
   input  logic [20:0] csr_wdata
);
   localparam int IB = $clog2(MAX_SEGMENTS);
   localparam int CB = $clog2(MAX_SEGMENTS + 1);
   localparam int AW = cfa_pkg::AddrBits;
   localparam int OW = cfa_pkg::OwnerBits;
   localparam logic [CB-1:0] MaxCount = CB'(MAX_SEGMENTS);

   logic [AW-1:0] seg_start_mem [MAX_SEGMENTS];
   logic [AW-1:0] seg_end_mem   [MAX_SEGMENTS];
   logic [OW-1:0] seg_owner_mem [MAX_SEGMENTS];

   cfa_pkg::state_type state_ff, state_in;
   logic [CB-1:0] count_ff, count_in;
   logic [AW-1:0] mem_size_ff;
   logic [CB-1:0] idx_ff, idx_in;
   cfa_pkg::op_type op_ff, op_in;
   cfa_pkg::fit_type fit_ff, fit_in;
   logic [OW-1:0] pid_ff, pid_in;
   logic [AW-1:0] size_ff, size_in;
   logic found_ff, found_in;
   logic [CB-1:0] pos_ff, pos_in;
   logic [AW-1:0] best_ff, best_in;
   logic [AW-1:0] at_ff, at_in;
   logic gap_ff, gap_in;

   // read port registers
   logic [AW-1:0] rd_s_ff, rd_e_ff, rd_ns_ff;
   logic [OW-1:0] rd_o_ff;
   logic [IB-1:0] ra_ff, ra_in;

   logic [1:0] o_st_ff, o_st_in;
   logic [AW-1:0] o_s_ff, o_s_in, o_e_ff, o_e_in;
   logic [OW-1:0] o_o_ff, o_o_in;
   logic o_u_ff, o_u_in, o_l_ff, o_l_in;

   logic we;
   logic [IB-1:0] wa;
   logic [AW-1:0] ws, wend;
   logic [OW-1:0] wo;

   always_ff @(posedge clock) begin
      if (we) begin
         seg_start_mem[wa] <= ws;
         seg_end_mem[wa]   <= wend;
         seg_owner_mem[wa] <= wo;
      end
      rd_s_ff  <= seg_start_mem[ra_ff];
      rd_e_ff  <= seg_end_mem[ra_ff];
      rd_o_ff  <= seg_owner_mem[ra_ff];
      rd_ns_ff <= seg_start_mem[IB'(ra_ff + IB'(1))];
      ra_ff <= ra_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfa_pkg::S_IDLE;
         count_ff <= '0;
         mem_size_ff <= AW'(cfa_pkg::MemorySizeReset);
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_we) mem_size_ff <= AW'(csr_wdata);
      end
      idx_ff <= idx_in; op_ff <= op_in; fit_ff <= fit_in; pid_ff <= pid_in;
      size_ff <= size_in; found_ff <= found_in; pos_ff <= pos_in;
      best_ff <= best_in; at_ff <= at_in; gap_ff <= gap_in;
      o_st_ff <= o_st_in; o_s_ff <= o_s_in; o_e_ff <= o_e_in;
      o_o_ff <= o_o_in; o_u_ff <= o_u_in; o_l_ff <= o_l_in;
   end

   logic last_ent;
   logic [AW-1:0] lim, hole;
   logic better;

   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff;
      op_in = op_ff; fit_in = fit_ff; pid_in = pid_ff; size_in = size_ff;
      found_in = found_ff; pos_in = pos_ff; best_in = best_ff; at_in = at_ff;
      gap_in = gap_ff;
      o_st_in = o_st_ff; o_s_in = o_s_ff; o_e_in = o_e_ff; o_o_in = o_o_ff;
      o_u_in = o_u_ff; o_l_in = o_l_ff;
      ra_in = ra_ff;
      we = 1'b0; wa = ra_ff; ws = rd_s_ff; wend = rd_e_ff; wo = rd_o_ff;
      req_tready = 1'b0; rsp_tvalid = 1'b0;
      last_ent = (idx_ff + CB'(1) == count_ff);
      lim = last_ent ? mem_size_ff : rd_ns_ff;
      hole = (lim > rd_e_ff) ? lim - rd_e_ff : '0;
      better = 1'b0;
      unique case (state_ff)
         cfa_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in = cfa_pkg::op_type'(req_tdata[1:0]);
               fit_in = cfa_pkg::fit_type'(req_tdata[3:2]);
               pid_in = OW'(req_tdata[11:4]);
               size_in = AW'(req_tdata[32:12]);
               idx_in = '0; ra_in = '0; at_in = '0; gap_in = 1'b1;
               o_st_in = cfa_pkg::ST_OK; o_s_in = '0; o_e_in = '0;
               o_o_in = '0; o_u_in = 1'b0; o_l_in = 1'b1;
               state_in = cfa_pkg::S_SCAN_RD;
               if (cfa_pkg::op_type'(req_tdata[1:0]) == cfa_pkg::OP_REQUEST &&
                   count_ff >= MaxCount) begin
                  o_st_in = cfa_pkg::ST_FULL; state_in = cfa_pkg::S_OUT;
               end
            end
         end
         cfa_pkg::S_SCAN_RD: begin
            // wait for the registered read at ra_ff
            unique case (op_ff)
               cfa_pkg::OP_COMPACT: state_in = cfa_pkg::S_COMPACT;
               cfa_pkg::OP_REPORT:  state_in = cfa_pkg::S_REPORT;
               default:             state_in = cfa_pkg::S_SCAN;
            endcase
            if (count_ff == '0) begin
               unique case (op_ff)
                  cfa_pkg::OP_REQUEST: begin
                     if (mem_size_ff > size_ff) begin
                        pos_in = '0; found_in = 1'b1; o_s_in = '0;
                        state_in = cfa_pkg::S_INSERT;
                     end else begin
                        o_st_in = cfa_pkg::ST_NO_HOLE; state_in = cfa_pkg::S_OUT;
                     end
                  end
                  cfa_pkg::OP_RELEASE: begin
                     o_st_in = cfa_pkg::ST_ABSENT; state_in = cfa_pkg::S_OUT;
                  end
                  cfa_pkg::OP_COMPACT: state_in = cfa_pkg::S_OUT;
                  default: begin
                     o_e_in = mem_size_ff; state_in = cfa_pkg::S_OUT;
                  end
               endcase
            end
         end
         cfa_pkg::S_SCAN: begin
            if (op_ff == cfa_pkg::OP_RELEASE) begin
               if (rd_o_ff == pid_ff) begin
                  o_s_in = rd_s_ff; o_e_in = rd_e_ff; o_o_in = pid_ff;
                  pos_in = idx_ff;
                  if (last_ent) begin
                     count_in = count_ff - CB'(1); state_in = cfa_pkg::S_OUT;
                  end else begin
                     ra_in = IB'(idx_ff + CB'(1)); state_in = cfa_pkg::S_SHIFT_DOWN;
                  end
               end else if (last_ent) begin
                  o_st_in = cfa_pkg::ST_ABSENT; state_in = cfa_pkg::S_OUT;
               end else begin
                  idx_in = idx_ff + CB'(1); ra_in = IB'(idx_ff + CB'(1));
                  state_in = cfa_pkg::S_SCAN_RD;
               end
            end else begin
               if (idx_ff == '0) begin
                  found_in = rd_s_ff > size_ff; pos_in = '0; o_s_in = '0;
                  best_in = rd_s_ff;
               end
               if (idx_ff == '0 && rd_s_ff > size_ff &&
                   (fit_ff == cfa_pkg::FIT_FIRST || fit_ff == cfa_pkg::FIT_OTHER)) begin
                  state_in = cfa_pkg::S_INSERT; // front hole fits
               end else begin
                  if (hole > size_ff) begin
                     unique case (fit_ff)
                        cfa_pkg::FIT_BEST:
                           better = !((idx_ff == '0) ? rd_s_ff > size_ff : found_ff) ||
                                    hole < ((idx_ff == '0) ? rd_s_ff : best_ff);
                        cfa_pkg::FIT_WORST:
                           better = hole > ((idx_ff == '0) ? rd_s_ff : best_ff);
                        default: better = 1'b1;
                     endcase
                  end
                  if (better) begin
                     found_in = 1'b1; best_in = hole; pos_in = idx_ff + CB'(1);
                     o_s_in = rd_e_ff;
                  end
                  if (better && (fit_ff == cfa_pkg::FIT_FIRST ||
                                 fit_ff == cfa_pkg::FIT_OTHER)) begin
                     found_in = 1'b1; state_in = cfa_pkg::S_INSERT;
                  end else if (last_ent) begin
                     if (better || ((idx_ff == '0) ? rd_s_ff > size_ff : found_ff))
                        state_in = cfa_pkg::S_INSERT;
                     else begin
                        o_st_in = cfa_pkg::ST_NO_HOLE; state_in = cfa_pkg::S_OUT;
                     end
                  end else begin
                     idx_in = idx_ff + CB'(1); ra_in = IB'(idx_ff + CB'(1));
                     state_in = cfa_pkg::S_SCAN_RD;
                  end
               end
               if (state_in == cfa_pkg::S_INSERT) begin
                  idx_in = count_ff; ra_in = IB'(count_ff - CB'(1));
               end
            end
         end
         cfa_pkg::S_INSERT: begin
            // idx_ff walks down from count to pos; rd_* holds entry idx-1
            if (idx_ff == pos_ff) begin
               we = 1'b1; wa = IB'(pos_ff); ws = o_s_in;
               wend = AW'(o_s_ff + size_ff); wo = pid_ff;
               o_e_in = AW'(o_s_ff + size_ff); o_o_in = pid_ff; o_u_in = 1'b1;
               count_in = count_ff + CB'(1); state_in = cfa_pkg::S_OUT;
            end else begin
               state_in = cfa_pkg::S_SHIFT_UP;
            end
         end
         cfa_pkg::S_SHIFT_UP: begin
            we = 1'b1; wa = IB'(idx_ff);
            idx_in = idx_ff - CB'(1); ra_in = IB'(idx_ff - CB'(2));
            state_in = cfa_pkg::S_INSERT;
         end
         cfa_pkg::S_SHIFT_DOWN: begin
            // rd_* now holds entry pos+1 after its registered read
            if (!gap_ff) begin
               we = 1'b1; wa = IB'(pos_ff);
               if (pos_ff + CB'(2) == count_ff) begin
                  count_in = count_ff - CB'(1); state_in = cfa_pkg::S_OUT;
               end else begin
                  pos_in = pos_ff + CB'(1); ra_in = IB'(pos_ff + CB'(2));
               end
            end
            gap_in = !gap_ff;
         end
         cfa_pkg::S_COMPACT: begin
            we = 1'b1; wa = IB'(idx_ff); ws = at_ff;
            wend = AW'(at_ff + (rd_e_ff - rd_s_ff));
            at_in = wend; wo = rd_o_ff;
            if (last_ent) begin
               o_e_in = wend; state_in = cfa_pkg::S_OUT;
            end else begin
               idx_in = idx_ff + CB'(1); ra_in = IB'(idx_ff + CB'(1));
               state_in = cfa_pkg::S_SCAN_RD;
            end
         end
         cfa_pkg::S_REPORT: begin
            // at_ff: end of previous region; gap_ff: hole before entry pending
            rsp_tvalid = 1'b1; o_l_in = 1'b0;
            if (rsp_tready) begin
               if (gap_ff) gap_in = 1'b0;
               else begin
                  gap_in = 1'b1; at_in = rd_e_ff;
                  if (last_ent) state_in = (mem_size_ff > rd_e_ff) ?
                     cfa_pkg::S_OUT : cfa_pkg::S_IDLE;
                  else begin
                     idx_in = idx_ff + CB'(1); ra_in = IB'(idx_ff + CB'(1));
                     state_in = cfa_pkg::S_SCAN_RD;
                  end
               end
            end
            if (gap_ff && !(rd_s_ff > at_ff)) begin
               rsp_tvalid = 1'b0; gap_in = 1'b0;
            end
            if (state_in == cfa_pkg::S_OUT) begin
               o_st_in = cfa_pkg::ST_OK; o_s_in = rd_e_ff; o_e_in = mem_size_ff;
               o_o_in = '0; o_u_in = 1'b0; o_l_in = 1'b1;
            end
         end
         cfa_pkg::S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = cfa_pkg::S_IDLE;
         end
         default: state_in = cfa_pkg::S_IDLE;
      endcase
   end

   logic rep;
   logic rep_last;
   assign rep = (state_ff == cfa_pkg::S_REPORT);
   assign rep_last = !gap_ff && last_ent && !(mem_size_ff > rd_e_ff);

   always_comb begin
      rsp_tdata = '0;
      rsp_tlast = o_l_ff;
      if (rep) begin
         rsp_tlast = rep_last;
         if (gap_ff) begin
            rsp_tdata[22:2]  = 21'(at_ff);
            rsp_tdata[43:23] = 21'(rd_s_ff);
         end else begin
            rsp_tdata[22:2]  = 21'(rd_s_ff);
            rsp_tdata[43:23] = 21'(rd_e_ff);
            rsp_tdata[44 +: OW] = rd_o_ff;
            rsp_tdata[52] = 1'b1;
         end
      end else begin
         rsp_tdata[1:0]   = o_st_ff;
         rsp_tdata[22:2]  = 21'(o_s_ff);
         rsp_tdata[43:23] = 21'(o_e_ff);
         rsp_tdata[44 +: OW] = o_o_ff;
         rsp_tdata[52] = o_u_ff;
      end
   end
endmodule
